[hdl/tdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types, command codes and the key order of the timer deadline queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

   localparam int DEADLINE_W = 64;
   localparam int ID_W       = 32;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   // one stored timer
   typedef struct packed {
      logic                  valid;
      logic [DEADLINE_W-1:0] deadline;
      logic [ID_W-1:0]       id;
   } slot_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                  ins;
      logic                  pop;
      logic [DEADLINE_W-1:0] new_deadline;
      logic [ID_W-1:0]       new_id;
   } ctl_type;

   // strict order: deadline first, then id
   function automatic logic key_before(input logic [DEADLINE_W-1:0] da,
                                       input logic [ID_W-1:0]       ia,
                                       input logic [DEADLINE_W-1:0] db,
                                       input logic [ID_W-1:0]       ib);
      logic result;
      if (da != db) begin
         result = (da < db);
      end else begin
         result = (ia < ib);
      end
      return result;
   endfunction

endpackage
`default_nettype wire

[hdl/tdq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_cell
// One slot of the sorted chain: compares its key with a new timer and
// shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module tdq_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tdq_pkg::ctl_type ctl,
   input  wire tdq_pkg::slot_type prev_slot,
   input  wire logic             prev_ahead,
   input  wire tdq_pkg::slot_type next_slot,
   output tdq_pkg::slot_type     slot,
   output logic                  ahead
);
   import tdq_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DEADLINE_W-1:0] deadline_ff, deadline_in;
   logic [ID_W-1:0]       id_ff, id_in;

   // new timer orders ahead of this slot (always true for an empty slot)
   assign ahead = !valid_ff || key_before(ctl.new_deadline, ctl.new_id, deadline_ff, id_ff);

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      id_in       = id_ff;
      if (ctl.ins && ahead) begin
         if (prev_ahead) begin
            valid_in    = prev_slot.valid;
            deadline_in = prev_slot.deadline;
            id_in       = prev_slot.id;
         end else begin
            valid_in    = 1'b1;
            deadline_in = ctl.new_deadline;
            id_in       = ctl.new_id;
         end
      end else if (ctl.pop) begin
         valid_in    = next_slot.valid;
         deadline_in = next_slot.deadline;
         id_in       = next_slot.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      deadline_ff <= deadline_in;
      id_ff       <= id_in;
   end

   assign slot.valid    = valid_ff;
   assign slot.deadline = deadline_ff;
   assign slot.id       = id_ff;

endmodule
`default_nettype wire

[hdl/timer_deadline_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer_deadline_queue
// Sorted queue of pending timers held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per item: tick advances the ms counter, add
//   stores a timer due at now + req_delay_ms, check pops the head if due.
//   rsp_* returns exactly one result item per command, in order.
//   Every cell compares the new key in parallel and shifts one place, so
//   the queue update itself takes the accept cycle. The sleep value is
//   formed from the updated head and counter in the following cycle and
//   registered into the result; req_ready is low until then, so the block
//   takes no new item while one is still being processed.
//   A new item is taken in the same cycle an old result is being taken.
//   If rsp_ready stays low the result waits in the output register and
//   req_ready stays low until it is taken.
//   Reset empties the queue, clears the counter and the id sequence and
//   drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timer_deadline_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_delay_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_fired,
   output logic [31:0]      rsp_fired_timer_id,
   output logic [63:0]      rsp_fired_deadline,
   output logic [31:0]      rsp_assigned_id,
   output logic             rsp_add_dropped,
   output logic             rsp_queue_empty,
   output logic [63:0]      rsp_sleep_ms
);
   import tdq_pkg::*;

   slot_type                 slots [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   aheads;
   logic [QUEUE_DEPTH-1:0]   valid_vec;
   ctl_type                  ctl;

   logic [DEADLINE_W-1:0]    now_ff, now_in;
   logic [ID_W-1:0]          last_id_ff, last_id_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     fired_ff, fired_in;
   logic [ID_W-1:0]          fid_ff, fid_in;
   logic [DEADLINE_W-1:0]    fdl_ff, fdl_in;
   logic [ID_W-1:0]          aid_ff, aid_in;
   logic                     dropped_ff, dropped_in;
   logic                     empty_ff, empty_in;
   logic [DEADLINE_W-1:0]    sleep_ff, sleep_in;

   logic                     accept;
   logic                     full;
   logic                     due;
   logic [ID_W-1:0]          next_id;

   assign req_ready = !reset && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign full = slots[QUEUE_DEPTH-1].valid;
   assign due  = slots[0].valid && (slots[0].deadline <= now_ff);

   // ids skip zero on wrap
   always_comb begin
      next_id = last_id_ff + ID_W'(1);
      if (next_id == '0) begin
         next_id = ID_W'(1);
      end
   end

   assign ctl.ins          = accept && (req_cmd == CMD_ADD) && !full;
   assign ctl.pop          = accept && (req_cmd == CMD_CHECK) && due;
   assign ctl.new_deadline = now_ff + DEADLINE_W'(req_delay_ms);
   assign ctl.new_id       = next_id;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         slot_type prev_s;
         slot_type next_s;
         logic     prev_b;
         if (g == 0) begin : g_head
            assign prev_s = '0;
            assign prev_b = 1'b0;
         end else begin : g_body
            assign prev_s = slots[g-1];
            assign prev_b = aheads[g-1];
         end
         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_s = '0;
         end else begin : g_inner
            assign next_s = slots[g+1];
         end
         tdq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .prev_slot   (prev_s),
            .prev_ahead  (prev_b),
            .next_slot   (next_s),
            .slot        (slots[g]),
            .ahead       (aheads[g])
         );
         assign valid_vec[g] = slots[g].valid;
      end
   endgenerate

   always_comb begin
      now_in       = now_ff;
      last_id_in   = last_id_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      fired_in     = fired_ff;
      fid_in       = fid_ff;
      fdl_in       = fdl_ff;
      aid_in       = aid_ff;
      dropped_in   = dropped_ff;
      empty_in     = empty_ff;
      sleep_in     = sleep_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         pend_in    = 1'b1;
         fired_in   = 1'b0;
         fid_in     = '0;
         fdl_in     = '0;
         aid_in     = '0;
         dropped_in = 1'b0;
         unique case (req_cmd)
            CMD_TICK: begin
               now_in = now_ff + DEADLINE_W'(1);
            end
            CMD_ADD: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  last_id_in = next_id;
                  aid_in     = next_id;
               end
            end
            CMD_CHECK: begin
               if (due) begin
                  fired_in = 1'b1;
                  fid_in   = slots[0].id;
                  fdl_in   = slots[0].deadline;
               end
            end
            default: begin
            end
         endcase
      end

      // while pending: status from the updated head
      if (pend_ff) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         empty_in     = !slots[0].valid;
         sleep_in     = slots[0].valid ? (slots[0].deadline - now_ff) : '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         last_id_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         last_id_ff   <= last_id_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fired_ff   <= fired_in;
      fid_ff     <= fid_in;
      fdl_ff     <= fdl_in;
      aid_ff     <= aid_in;
      dropped_ff <= dropped_in;
      empty_ff   <= empty_in;
      sleep_ff   <= sleep_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fired          = fired_ff;
   assign rsp_fired_timer_id = fid_ff;
   assign rsp_fired_deadline = fdl_ff;
   assign rsp_assigned_id    = aid_ff;
   assign rsp_add_dropped    = dropped_ff;
   assign rsp_queue_empty    = empty_ff;
   assign rsp_sleep_ms       = sleep_ff;

   // occupied slots always form a prefix of the chain
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
      else $error("occupied slots are not a prefix");

   // an insert grows the queue by one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("insert did not add one timer");

   // a pop shrinks the queue by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
      else $error("pop did not remove one timer");

   // head never orders after the second slot
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      slots[1].valid |-> !key_before(slots[1].deadline, slots[1].id,
                                     slots[0].deadline, slots[0].id))
      else $error("queue head out of order");

endmodule
`default_nettype wire

[tb/sv/tdq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_checker
// Watches both channels of the timer deadline queue, keeps its own sorted
// copy of the pending timers and compares every result item in order.
// ----------------------------------------------------------------------------
module tdq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_delay_ms,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_fired,
   input  wire logic [31:0] rsp_fired_timer_id,
   input  wire logic [63:0] rsp_fired_deadline,
   input  wire logic [31:0] rsp_assigned_id,
   input  wire logic        rsp_add_dropped,
   input  wire logic        rsp_queue_empty,
   input  wire logic [63:0] rsp_sleep_ms,
   output int               error_count,
   output int               outstanding
);
   import tdq_pkg::*;

   typedef struct packed {
      logic [63:0] deadline;
      logic [31:0] id;
   } timer_slot_type;

   typedef struct packed {
      logic        fired;
      logic [31:0] fired_id;
      logic [63:0] fired_deadline;
      logic [31:0] assigned_id;
      logic        dropped;
      logic        empty;
      logic [63:0] sleep;
   } timer_status_type;

   logic [63:0]      now_ms_q   = '0;
   logic [31:0]      last_id_q  = '0;
   timer_slot_type   armed[$];
   timer_status_type status_fifo[$];
   int               errors     = 0;

   task automatic apply_command(input logic [1:0] cmd, input logic [31:0] delay,
                                output timer_status_type st);
      timer_slot_type fresh;
      int             pos;
      st = '0;
      case (cmd)
         CMD_TICK: begin
            now_ms_q = now_ms_q + 64'd1;
         end
         CMD_ADD: begin
            if (armed.size() >= QUEUE_DEPTH) begin
               st.dropped = 1'b1;
            end else begin
               // ids skip zero on wrap
               last_id_q = (last_id_q == '1) ? 32'd1 : last_id_q + 32'd1;
               fresh.deadline = now_ms_q + {32'd0, delay};
               fresh.id = last_id_q;
               pos = 0;
               // walk past every stored key that is not strictly later
               while (pos < armed.size() &&
                      !(fresh.deadline < armed[pos].deadline ||
                        (fresh.deadline == armed[pos].deadline &&
                         fresh.id < armed[pos].id))) begin
                  pos++;
               end
               armed.insert(pos, fresh);
               st.assigned_id = fresh.id;
            end
         end
         CMD_CHECK: begin
            if (armed.size() > 0 && armed[0].deadline <= now_ms_q) begin
               st.fired = 1'b1;
               st.fired_id = armed[0].id;
               st.fired_deadline = armed[0].deadline;
               armed.delete(0);
            end
         end
         default: begin
         end
      endcase
      if (armed.size() == 0) begin
         st.empty = 1'b1;
         st.sleep = '1;
      end else begin
         st.sleep = armed[0].deadline - now_ms_q;
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      timer_status_type st;
      timer_status_type want;
      if (reset) begin
         now_ms_q = '0;
         last_id_q = '0;
         armed.delete();
         status_fifo.delete();
      end else begin
         // results first: an item accepted at this edge cannot answer now
         if (rsp_valid && rsp_ready) begin
            if (status_fifo.size() == 0) begin
               $error("result item with nothing outstanding");
               errors++;
            end else begin
               want = status_fifo.pop_front();
               check_field("fired", 64'(want.fired), 64'(rsp_fired));
               check_field("fired_timer_id", 64'(want.fired_id), 64'(rsp_fired_timer_id));
               check_field("fired_deadline", want.fired_deadline, rsp_fired_deadline);
               check_field("assigned_id", 64'(want.assigned_id), 64'(rsp_assigned_id));
               check_field("add_dropped", 64'(want.dropped), 64'(rsp_add_dropped));
               check_field("queue_empty", 64'(want.empty), 64'(rsp_queue_empty));
               check_field("sleep_ms", want.sleep, rsp_sleep_ms);
            end
         end
         if (req_valid && req_ready) begin
            apply_command(req_cmd, req_delay_ms, st);
            status_fifo.push_back(st);
         end
      end
      outstanding <= status_fifo.size();
      error_count <= errors;
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick, add, check and unused commands into the timer deadline queue with
// bursty input and a stalling receiver; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
   import tdq_pkg::*;

   localparam int         DEPTH          = 16;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         ITEM_TARGET    = 1300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         HOLD_AFTER     = 400;
   localparam int         HOLD_CYCLES    = 250;

   localparam int MODE_MIX   = 0;
   localparam int MODE_FILL  = 1;
   localparam int MODE_DRAIN = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [31:0] req_delay_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_fired;
   logic [31:0] rsp_fired_timer_id;
   logic [63:0] rsp_fired_deadline;
   logic [31:0] rsp_assigned_id;
   logic        rsp_add_dropped;
   logic        rsp_queue_empty;
   logic [63:0] rsp_sleep_ms;

   int error_count;
   int outstanding;
   int quiet_cycles = 0;
   int burst_left   = 0;
   int far_left     = 4;

   always #6 clock = ~clock;

   timer_deadline_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_delay_ms       (req_delay_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_fired          (rsp_fired),
      .rsp_fired_timer_id (rsp_fired_timer_id),
      .rsp_fired_deadline (rsp_fired_deadline),
      .rsp_assigned_id    (rsp_assigned_id),
      .rsp_add_dropped    (rsp_add_dropped),
      .rsp_queue_empty    (rsp_queue_empty),
      .rsp_sleep_ms       (rsp_sleep_ms)
   );

   tdq_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_delay_ms       (req_delay_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_fired          (rsp_fired),
      .rsp_fired_timer_id (rsp_fired_timer_id),
      .rsp_fired_deadline (rsp_fired_deadline),
      .rsp_assigned_id    (rsp_assigned_id),
      .rsp_add_dropped    (rsp_add_dropped),
      .rsp_queue_empty    (rsp_queue_empty),
      .rsp_sleep_ms       (rsp_sleep_ms),
      .error_count        (error_count),
      .outstanding        (outstanding)
   );

   // offer one item; a fresh burst starts after a random gap, which may be zero
   task automatic offer(input logic [1:0] cmd, input logic [31:0] delay);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_delay_ms <= delay;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   task automatic pick_command(input int mode, output logic [1:0] cmd,
                               output logic [31:0] delay);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  cmd = (roll < 10) ? CMD_TICK : (roll < 85) ? CMD_ADD :
                           (roll < 98) ? CMD_CHECK : CMD_UNUSED;
         MODE_DRAIN: cmd = (roll < 50) ? CMD_TICK : (roll < 55) ? CMD_ADD :
                           (roll < 98) ? CMD_CHECK : CMD_UNUSED;
         default:    cmd = (roll < 30) ? CMD_TICK : (roll < 65) ? CMD_ADD :
                           (roll < 97) ? CMD_CHECK : CMD_UNUSED;
      endcase
      delay = $urandom;
      if (cmd == CMD_ADD) begin
         // far-off timers never fire, so only a few of them are let in
         if (far_left > 0 && $urandom_range(0, 29) == 0) begin
            far_left--;
         end else if ($urandom_range(0, 9) == 0) begin
            delay = $urandom_range(25, 200);
         end else begin
            delay = $urandom_range(0, 24);
         end
      end
   endtask

   // receiver: stall patterns, plus one long hold-off once traffic is going
   initial begin : receiver
      int mode;
      int span;
      int taken;
      bit held;
      taken = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(5, 60);
         repeat (span) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
            if (rsp_valid && rsp_ready) taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int          counted;
      int          mode;
      int          span;
      logic [1:0]  cmd;
      logic [31:0] delay;
      req_valid <= 1'b0;
      req_cmd <= CMD_TICK;
      req_delay_ms <= '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, tie on deadline, overdue head, due on equality
      offer(CMD_CHECK, 32'd0);
      offer(CMD_UNUSED, 32'hFFFF_FFFF);
      offer(CMD_TICK, 32'hA5A5_5A5A);
      offer(CMD_ADD, 32'd0);
      offer(CMD_ADD, 32'd0);
      offer(CMD_ADD, 32'hFFFF_FFFF);
      offer(CMD_ADD, 32'd3);
      offer(CMD_TICK, 32'd0);
      offer(CMD_UNUSED, 32'h5A5A_A5A5);
      offer(CMD_CHECK, 32'hFFFF_FFFF);
      offer(CMD_CHECK, 32'd0);
      offer(CMD_CHECK, 32'd0);
      offer(CMD_TICK, 32'd0);
      offer(CMD_TICK, 32'd0);
      offer(CMD_CHECK, 32'd0);
      offer(CMD_CHECK, 32'd0);
      offer(CMD_ADD, 32'd1);

      // random: segments that fill the queue, drain it, or mix
      counted = 0;
      while (counted < ITEM_TARGET) begin
         mode = $urandom_range(0, 3);
         if (mode > MODE_DRAIN) mode = MODE_MIX;
         span = $urandom_range(16, 64);
         repeat (span) begin
            pick_command(mode, cmd, delay);
            offer(cmd, delay);
            if (cmd != CMD_UNUSED) counted++;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
